/* rtl/complex_arithmetic_unit_macros.svh */
// Assertion macros used by the port checker of the complex arithmetic unit.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen.
`define CAU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps

package cau_pkg;

	// Operation codes carried in req_type.
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_MAG  = 3'd4,
		OP_ARG  = 3'd5,
		OP_CONJ = 3'd6,
		OP_EQ   = 3'd7
	} cau_op_t;

	// Work class chosen by the front end.
	typedef enum logic [2:0] {
		CL_SIMPLE = 3'd0,
		CL_MUL    = 3'd1,
		CL_DIV    = 3'd2,
		CL_MAG    = 3'd3,
		CL_ARG    = 3'd4
	} cau_class_t;

	// Control word at the head of the request queue.
	typedef struct packed {
		logic       valid;
		cau_class_t cls;
		cau_op_t    op;
	} cau_head_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_PROD   = 4'd1,
		ST_MULSUM = 4'd2,
		ST_MULFIN = 4'd3,
		ST_DEN    = 4'd4,
		ST_DPREP  = 4'd5,
		ST_DIV    = 4'd6,
		ST_DFIN   = 4'd7,
		ST_SQSUM  = 4'd8,
		ST_SQRT   = 4'd9,
		ST_SQFIN  = 4'd10,
		ST_ASET   = 4'd11,
		ST_ANORM  = 4'd12,
		ST_ACORD  = 4'd13,
		ST_AFIN   = 4'd14
	} cau_state_t;

	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;
	localparam int ANG_FRAC   = 30;
	localparam int NORM_SHIFT = 40;
	localparam int ZW         = 34;

	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [15:0] EQ_TOL_RESET = 16'd1;
	localparam logic        REG_EQ_TOL   = 1'b0;

	// Truncated atan(2^-i) in Q30.
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* rtl/cau_front.sv */
`timescale 1ns / 1ps

module cau_front #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	input  logic                         pop,
	output cau_pkg::cau_head_t           head,
	output logic signed [DATA_WIDTH-1:0] h_ar,
	output logic signed [DATA_WIDTH-1:0] h_ai,
	output logic signed [DATA_WIDTH-1:0] h_br,
	output logic signed [DATA_WIDTH-1:0] h_bi
);

	localparam int CNTW = $clog2(cau_pkg::QDEPTH + 1);

	cau_pkg::cau_op_t          op_mem_q  [cau_pkg::QDEPTH];
	cau_pkg::cau_class_t       cls_mem_q [cau_pkg::QDEPTH];
	logic signed [DATA_WIDTH-1:0] ar_mem_q [cau_pkg::QDEPTH];
	logic signed [DATA_WIDTH-1:0] ai_mem_q [cau_pkg::QDEPTH];
	logic signed [DATA_WIDTH-1:0] br_mem_q [cau_pkg::QDEPTH];
	logic signed [DATA_WIDTH-1:0] bi_mem_q [cau_pkg::QDEPTH];

	logic [cau_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]         cnt_q;
	logic                    push;
	cau_pkg::cau_op_t        op_in;
	cau_pkg::cau_class_t     cls_in;

	assign busy = (cnt_q == CNTW'(cau_pkg::QDEPTH));
	assign push = start && !busy;
	assign op_in = cau_pkg::cau_op_t'(req_type);

	// Classify the request; a division by zero needs no divider.
	always_comb begin
		case (op_in)
			cau_pkg::OP_MUL: cls_in = cau_pkg::CL_MUL;
			cau_pkg::OP_DIV: begin
				if (b_re == '0 && b_im == '0) begin
					cls_in = cau_pkg::CL_SIMPLE;
				end else begin
					cls_in = cau_pkg::CL_DIV;
				end
			end
			cau_pkg::OP_MAG: cls_in = cau_pkg::CL_MAG;
			cau_pkg::OP_ARG: cls_in = cau_pkg::CL_ARG;
			default:         cls_in = cau_pkg::CL_SIMPLE;
		endcase
	end

	// Queue storage, written on each transfer.
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem_q[wr_ptr_q]  <= op_in;
			cls_mem_q[wr_ptr_q] <= cls_in;
			ar_mem_q[wr_ptr_q]  <= a_re;
			ai_mem_q[wr_ptr_q]  <= a_im;
			br_mem_q[wr_ptr_q]  <= b_re;
			bi_mem_q[wr_ptr_q]  <= b_im;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Head of the queue.
	always_comb begin
		head.valid = (cnt_q != '0);
		head.cls   = cls_mem_q[rd_ptr_q];
		head.op    = op_mem_q[rd_ptr_q];
		h_ar       = ar_mem_q[rd_ptr_q];
		h_ai       = ai_mem_q[rd_ptr_q];
		h_br       = br_mem_q[rd_ptr_q];
		h_bi       = bi_mem_q[rd_ptr_q];
	end

endmodule

/* rtl/cau_back.sv */
`timescale 1ns / 1ps

module cau_back #(
	parameter int DATA_WIDTH   = 32,
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [15:0]                  eq_tol,
	input  cau_pkg::cau_head_t           head,
	input  logic signed [DATA_WIDTH-1:0] h_ar,
	input  logic signed [DATA_WIDTH-1:0] h_ai,
	input  logic signed [DATA_WIDTH-1:0] h_br,
	input  logic signed [DATA_WIDTH-1:0] h_bi,
	output logic                         pop,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         is_equal,
	output logic                         div_by_zero,
	output logic                         saturated
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int SW  = 2 * W + 1;
	localparam int NB  = SW + F;
	localparam int QW  = W + 1;
	localparam int RW  = 2 * W + 1;
	localparam int DCW = $clog2(NB + 1);
	localparam int SQW = W + 3;
	localparam int SCW = $clog2(W + 1);
	localparam int CW  = ((W > cau_pkg::NORM_SHIFT + 1) ? W : cau_pkg::NORM_SHIFT + 1) + 4;
	localparam int NS  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam int ICW = $clog2(NS + 1);
	localparam int ZW  = cau_pkg::ZW;
	localparam int SH  = cau_pkg::ANG_FRAC - F;
	localparam int MW  = (SW > ZW + 1) ? SW : ZW + 1;

	localparam logic signed [ZW:0]   RND     = (SH > 0) ? ((ZW + 1)'(1) << (SH > 0 ? SH - 1 : 0))
		: '0;
	localparam logic [MW-1:0]        LIM     = MW'(1) << (W - 1);
	localparam logic [W-1:0]         MAXV    = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0]         MINV    = {1'b1, {(W - 1){1'b0}}};
	localparam logic [CW-1:0]        NLIM    = CW'(1) << cau_pkg::NORM_SHIFT;

	// Clamp a sign and magnitude to the word; the top bit of the result is the flag.
	function automatic logic [W:0] sat_sm(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] t;
		t = MW'(0) - mag;
		if (!neg) begin
			if (mag > LIM - 1'b1) return {1'b1, MAXV};
			return {1'b0, mag[W-1:0]};
		end
		if (mag > LIM) return {1'b1, MINV};
		return {1'b0, t[W-1:0]};
	endfunction

	function automatic logic [W:0] sat_s(input logic signed [MW-1:0] v);
		logic [MW-1:0] m;
		m = v[MW-1] ? MW'(-v) : MW'(v);
		return sat_sm(v[MW-1], m);
	endfunction

	cau_pkg::cau_state_t state_q, state_d;
	cau_pkg::cau_class_t cls_q;

	logic signed [W-1:0]  ar_q, ai_q, br_q, bi_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [SW-1:0] s_re_q, s_im_q;
	logic [PW-1:0]        den_q, sq_src_q;
	logic [NB-1:0]        num_re_q, num_im_q;
	logic [RW-1:0]        rem_re_q, rem_im_q;
	logic [QW-1:0]        q_re_q, q_im_q;
	logic                 ovf_re_q, ovf_im_q, neg_re_q, neg_im_q;
	logic [DCW-1:0]       dcnt_q;
	logic [SQW-1:0]       sq_rem_q;
	logic [W-1:0]         root_q;
	logic [SCW-1:0]       scnt_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [ICW-1:0]       icnt_q;

	// Combinational helpers.
	logic                 mul_sq;
	logic signed [W-1:0]  m0a, m0b, m1a, m1b;
	logic signed [PW-1:0] prod0, prod1, prod2, prod3;
	logic [CW-1:0]        ax, ay;
	logic                 fin_valid, fin_eq, fin_dz, fin_sat;
	logic [W-1:0]         fin_re, fin_im;

	// Multipliers: two are shared between products and squares; two always form cross products.
	always_comb begin
		m0a   = mul_sq ? ((state_q == cau_pkg::ST_DEN) ? br_q : ar_q) : ar_q;
		m0b   = mul_sq ? ((state_q == cau_pkg::ST_DEN) ? br_q : ar_q) : br_q;
		m1a   = mul_sq ? ((state_q == cau_pkg::ST_DEN) ? bi_q : ai_q) : ai_q;
		m1b   = mul_sq ? ((state_q == cau_pkg::ST_DEN) ? bi_q : ai_q) : bi_q;
		prod0 = m0a * m0b;
		prod1 = m1a * m1b;
		prod2 = ar_q * bi_q;
		prod3 = ai_q * br_q;
		ax    = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
		ay    = y_q[CW-1] ? CW'(-y_q) : CW'(y_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cau_pkg::ST_IDLE: begin
				if (head.valid) begin
					case (head.cls)
						cau_pkg::CL_MUL: state_d = cau_pkg::ST_PROD;
						cau_pkg::CL_DIV: state_d = cau_pkg::ST_PROD;
						cau_pkg::CL_MAG: state_d = cau_pkg::ST_PROD;
						cau_pkg::CL_ARG: state_d = cau_pkg::ST_ASET;
						default:         state_d = cau_pkg::ST_IDLE;
					endcase
				end
			end
			cau_pkg::ST_PROD: begin
				case (cls_q)
					cau_pkg::CL_DIV: state_d = cau_pkg::ST_DEN;
					cau_pkg::CL_MAG: state_d = cau_pkg::ST_SQSUM;
					default:         state_d = cau_pkg::ST_MULSUM;
				endcase
			end
			cau_pkg::ST_MULSUM: state_d = cau_pkg::ST_MULFIN;
			cau_pkg::ST_DEN:    state_d = cau_pkg::ST_DPREP;
			cau_pkg::ST_DPREP:  state_d = cau_pkg::ST_DIV;
			cau_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(NB - 1)) state_d = cau_pkg::ST_DFIN;
			end
			cau_pkg::ST_SQSUM:  state_d = cau_pkg::ST_SQRT;
			cau_pkg::ST_SQRT: begin
				if (scnt_q == SCW'(W - 1)) state_d = cau_pkg::ST_SQFIN;
			end
			cau_pkg::ST_ASET: begin
				if (ai_q == '0 || ar_q == '0) begin
					state_d = cau_pkg::ST_AFIN;
				end else begin
					state_d = cau_pkg::ST_ANORM;
				end
			end
			cau_pkg::ST_ANORM: begin
				if (!(ax < NLIM && ay < NLIM)) state_d = cau_pkg::ST_ACORD;
			end
			cau_pkg::ST_ACORD: begin
				if (icnt_q == ICW'(NS - 1)) state_d = cau_pkg::ST_AFIN;
			end
			default: state_d = cau_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop, multiplier mode and finished results.
	always_comb begin
		logic signed [W:0]    d_re, d_im;
		logic [W:0]           e_re, e_im, t_re, t_im;
		logic [SW-1:0]        m_re, m_im;
		logic [MW-1:0]        qm_re, qm_im;
		logic signed [ZW:0]   zx, zr;
		pop       = (state_q == cau_pkg::ST_IDLE) && head.valid;
		mul_sq    = (state_q == cau_pkg::ST_DEN) ||
			((state_q == cau_pkg::ST_PROD) && (cls_q == cau_pkg::CL_MAG));
		fin_valid = 1'b0;
		fin_re    = '0;
		fin_im    = '0;
		fin_eq    = 1'b0;
		fin_dz    = 1'b0;
		fin_sat   = 1'b0;
		t_re      = '0;
		t_im      = '0;
		d_re      = '0;
		d_im      = '0;
		e_re      = '0;
		e_im      = '0;
		m_re      = s_re_q[SW-1] ? SW'(-s_re_q) : SW'(s_re_q);
		m_im      = s_im_q[SW-1] ? SW'(-s_im_q) : SW'(s_im_q);
		qm_re     = ovf_re_q ? '1 : MW'(q_re_q);
		qm_im     = ovf_im_q ? '1 : MW'(q_im_q);
		zx        = (ZW + 1)'(z_q) + RND;
		zr        = zx >>> SH;
		case (state_q)
			cau_pkg::ST_IDLE: begin
				if (head.valid && head.cls == cau_pkg::CL_SIMPLE) begin
					fin_valid = 1'b1;
					case (head.op)
						cau_pkg::OP_ADD: begin
							t_re = sat_s(MW'((W + 1)'(h_ar) + (W + 1)'(h_br)));
							t_im = sat_s(MW'((W + 1)'(h_ai) + (W + 1)'(h_bi)));
						end
						cau_pkg::OP_SUB: begin
							t_re = sat_s(MW'((W + 1)'(h_ar) - (W + 1)'(h_br)));
							t_im = sat_s(MW'((W + 1)'(h_ai) - (W + 1)'(h_bi)));
						end
						cau_pkg::OP_CONJ: begin
							t_re = {1'b0, h_ar};
							t_im = sat_s(MW'((W + 1)'(0) - (W + 1)'(h_ai)));
						end
						cau_pkg::OP_DIV: begin
							fin_dz = 1'b1;
						end
						cau_pkg::OP_EQ: begin
							d_re   = (W + 1)'(h_ar) - (W + 1)'(h_br);
							d_im   = (W + 1)'(h_ai) - (W + 1)'(h_bi);
							e_re   = d_re[W] ? (W + 1)'(-d_re) : (W + 1)'(d_re);
							e_im   = d_im[W] ? (W + 1)'(-d_im) : (W + 1)'(d_im);
							fin_eq = (e_re <= (W + 1)'(eq_tol)) && (e_im <= (W + 1)'(eq_tol));
						end
						default: begin
							t_re = '0;
						end
					endcase
				end
			end
			cau_pkg::ST_MULFIN: begin
				fin_valid = 1'b1;
				t_re = sat_sm(s_re_q[SW-1], MW'(m_re >> F));
				t_im = sat_sm(s_im_q[SW-1], MW'(m_im >> F));
			end
			cau_pkg::ST_DFIN: begin
				fin_valid = 1'b1;
				t_re = sat_sm(neg_re_q, qm_re);
				t_im = sat_sm(neg_im_q, qm_im);
			end
			cau_pkg::ST_SQFIN: begin
				fin_valid = 1'b1;
				t_re = sat_sm(1'b0, MW'(root_q));
			end
			cau_pkg::ST_AFIN: begin
				fin_valid = 1'b1;
				t_re = sat_s(MW'(zr));
			end
			default: begin
				fin_valid = 1'b0;
			end
		endcase
		fin_re  = t_re[W-1:0];
		fin_im  = t_im[W-1:0];
		fin_sat = t_re[W] | t_im[W];
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers of the long operations.
	always_ff @(posedge clk) begin
		logic [RW-1:0] r_re, r_im;
		logic [SQW-1:0] r4, trial;
		logic signed [CW-1:0] dx, dy;
		case (state_q)
			cau_pkg::ST_IDLE: begin
				if (pop) begin
					cls_q <= head.cls;
					ar_q  <= h_ar;
					ai_q  <= h_ai;
					br_q  <= h_br;
					bi_q  <= h_bi;
				end
			end
			cau_pkg::ST_PROD: begin
				p0_q <= prod0;
				p1_q <= prod1;
				p2_q <= prod2;
				p3_q <= prod3;
			end
			cau_pkg::ST_MULSUM: begin
				s_re_q <= SW'(p0_q) - SW'(p1_q);
				s_im_q <= SW'(p2_q) + SW'(p3_q);
			end
			cau_pkg::ST_DEN: begin
				// Numerators of a times conj(b); squares of b go to the products.
				s_re_q <= SW'(p0_q) + SW'(p1_q);
				s_im_q <= SW'(p3_q) - SW'(p2_q);
				p0_q   <= prod0;
				p1_q   <= prod1;
			end
			cau_pkg::ST_DPREP: begin
				den_q    <= PW'(p0_q) + PW'(p1_q);
				neg_re_q <= s_re_q[SW-1];
				neg_im_q <= s_im_q[SW-1];
				num_re_q <= {(s_re_q[SW-1] ? SW'(-s_re_q) : SW'(s_re_q)), {F{1'b0}}};
				num_im_q <= {(s_im_q[SW-1] ? SW'(-s_im_q) : SW'(s_im_q)), {F{1'b0}}};
				rem_re_q <= '0;
				rem_im_q <= '0;
				q_re_q   <= '0;
				q_im_q   <= '0;
				ovf_re_q <= 1'b0;
				ovf_im_q <= 1'b0;
				dcnt_q   <= '0;
			end
			cau_pkg::ST_DIV: begin
				// One quotient bit per cycle for both parts.
				r_re = {rem_re_q[RW-2:0], num_re_q[NB-1]};
				r_im = {rem_im_q[RW-2:0], num_im_q[NB-1]};
				if (r_re >= RW'(den_q)) begin
					rem_re_q <= r_re - RW'(den_q);
					q_re_q   <= {q_re_q[QW-2:0], 1'b1};
				end else begin
					rem_re_q <= r_re;
					q_re_q   <= {q_re_q[QW-2:0], 1'b0};
				end
				if (r_im >= RW'(den_q)) begin
					rem_im_q <= r_im - RW'(den_q);
					q_im_q   <= {q_im_q[QW-2:0], 1'b1};
				end else begin
					rem_im_q <= r_im;
					q_im_q   <= {q_im_q[QW-2:0], 1'b0};
				end
				ovf_re_q <= ovf_re_q | q_re_q[QW-1];
				ovf_im_q <= ovf_im_q | q_im_q[QW-1];
				num_re_q <= num_re_q << 1;
				num_im_q <= num_im_q << 1;
				dcnt_q   <= dcnt_q + 1'b1;
			end
			cau_pkg::ST_SQSUM: begin
				sq_src_q <= PW'(p0_q) + PW'(p1_q);
				sq_rem_q <= '0;
				root_q   <= '0;
				scnt_q   <= '0;
			end
			cau_pkg::ST_SQRT: begin
				// One root bit per cycle.
				r4    = {sq_rem_q[SQW-3:0], sq_src_q[PW-1:PW-2]};
				trial = SQW'({root_q, 2'b01});
				if (r4 >= trial) begin
					sq_rem_q <= r4 - trial;
					root_q   <= {root_q[W-2:0], 1'b1};
				end else begin
					sq_rem_q <= r4;
					root_q   <= {root_q[W-2:0], 1'b0};
				end
				sq_src_q <= sq_src_q << 2;
				scnt_q   <= scnt_q + 1'b1;
			end
			cau_pkg::ST_ASET: begin
				// Axis cases, then fold the left half plane onto the right.
				icnt_q <= '0;
				if (ai_q == '0) begin
					z_q <= ar_q[W-1] ? cau_pkg::PI_Q30 : '0;
				end else if (ar_q == '0) begin
					z_q <= ai_q[W-1] ? -cau_pkg::HALF_PI_Q30 : cau_pkg::HALF_PI_Q30;
				end else if (ar_q[W-1]) begin
					if (!ai_q[W-1]) begin
						x_q <= CW'(ai_q);
						y_q <= -CW'(ar_q);
						z_q <= cau_pkg::HALF_PI_Q30;
					end else begin
						x_q <= -CW'(ai_q);
						y_q <= CW'(ar_q);
						z_q <= -cau_pkg::HALF_PI_Q30;
					end
				end else begin
					x_q <= CW'(ar_q);
					y_q <= CW'(ai_q);
					z_q <= '0;
				end
			end
			cau_pkg::ST_ANORM: begin
				if (ax < NLIM && ay < NLIM) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			cau_pkg::ST_ACORD: begin
				// One vectoring rotation per cycle.
				dx = y_q >>> icnt_q;
				dy = x_q >>> icnt_q;
				if (!y_q[CW-1] && y_q != '0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ZW'(cau_pkg::atan_q30(5'(icnt_q)));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ZW'(cau_pkg::atan_q30(5'(icnt_q)));
				end
				icnt_q <= icnt_q + 1'b1;
			end
			default: begin
				cls_q <= cls_q;
			end
		endcase
	end

	// Result register: one cycle strobe per finished request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid) begin
			res_re      <= fin_re;
			res_im      <= fin_im;
			is_equal    <= fin_eq;
			div_by_zero <= fin_dz;
			saturated   <= fin_sat;
		end
	end

endmodule

/* rtl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Fixed-point complex ALU on signed operands (DATA_WIDTH bits, FRAC_BITS fraction bits).
// Request channel: a transfer happens at a rising edge with start high and busy low;
// req_type, a_re, a_im, b_re and b_im are sampled at that edge. Requests wait in a
// four-entry queue, so busy rises only when the queue is full.
// Result channel: done is high for exactly one cycle with res_re, res_im and the flags;
// results leave in request order and the receiver cannot hold them off.
// Add, sub, conjugate, equality and division by zero finish straight from the queue head;
// multiply passes through product, sum and final states; divide computes one quotient bit
// per cycle; magnitude computes one root bit per cycle; argument handles the axes directly,
// else normalizes the vector and then runs min(CORDIC_STEPS,32) rotations.
// Throughput: one simple request per cycle; a long request holds the shared back end
// for its full latency while the queue keeps taking requests until it is full.
// Register eq_tolerance at byte address 0 through the APB port, reset value 1.
// Reset clears the queue, the sequencer and the result strobe; no clearing pass.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH   = 32,
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         is_equal,
	output logic                         div_by_zero,
	output logic                         saturated,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [15:0]                  eq_tol_q;
	logic                         pop;
	cau_pkg::cau_head_t           head;
	logic signed [DATA_WIDTH-1:0] h_ar, h_ai, h_br, h_bi;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cau_pkg::REG_EQ_TOL) ? {16'd0, eq_tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_tol_q <= cau_pkg::EQ_TOL_RESET;
		end else if (psel && penable && pwrite && paddr[2] == cau_pkg::REG_EQ_TOL) begin
			eq_tol_q <= pwdata[15:0];
		end
	end

	// Front end: accept, classify, queue.
	cau_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req_type(req_type),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.pop     (pop),
		.head    (head),
		.h_ar    (h_ar),
		.h_ai    (h_ai),
		.h_br    (h_br),
		.h_bi    (h_bi)
	);

	// Back end: arithmetic sequencer and result register.
	cau_back #(
		.DATA_WIDTH  (DATA_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eq_tol     (eq_tol_q),
		.head       (head),
		.h_ar       (h_ar),
		.h_ai       (h_ai),
		.h_br       (h_br),
		.h_bi       (h_bi),
		.pop        (pop),
		.done       (done),
		.res_re     (res_re),
		.res_im     (res_im),
		.is_equal   (is_equal),
		.div_by_zero(div_by_zero),
		.saturated  (saturated)
	);

endmodule

/* rtl/cau_port_checker.sv */
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_macros.svh"

module cau_port_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] res_re,
	input logic signed [DATA_WIDTH-1:0] res_im,
	input logic                         is_equal,
	input logic                         div_by_zero,
	input logic                         saturated
);

	// A zero divisor gives zero and never a clamp.
	`CAU_ASSERT_IMP(ast_dz_zero, done && div_by_zero, res_re == '0 && res_im == '0 && !saturated, "zero divisor result is not clean")

	// The equality test leaves both parts at zero.
	`CAU_ASSERT_IMP(ast_eq_zero, done && is_equal, res_re == '0 && res_im == '0, "equality result carries data")

	// Equality and division flags belong to different operations.
	`CAU_ASSERT_NEVER(ast_flag_mix, done && is_equal && (div_by_zero || saturated), "flags from different operations")

endmodule

bind complex_arithmetic_unit cau_port_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_port_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.done       (done),
	.res_re     (res_re),
	.res_im     (res_im),
	.is_equal   (is_equal),
	.div_by_zero(div_by_zero),
	.saturated  (saturated)
);
